@@ src/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 8;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 8;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int ELEM_W   = 8;

  // wide enough to index any cell up to the largest supported capacity
  localparam int CELL_IDX_W = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_BACK  = 3'd1,
    KIND_INS_AT    = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_BACK  = 3'd4,
    KIND_DEL_AT    = 3'd5,
    KIND_DUMP      = 3'd6
  } ple_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_BAD   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } ple_status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } ple_cell_op_t;

  typedef struct packed {
    ple_cell_op_t            op;
    logic [CELL_IDX_W-1:0]   idx;
  } ple_cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } ple_state_t;

endpackage

@@ src/ple_cell.sv @@
// One storage cell of the shifting list chain.
module ple_cell
  import ple_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  ple_cell_ctl_t         ctl,
  input  logic [DATA_WIDTH-1:0] left_d,
  input  logic [DATA_WIDTH-1:0] right_d,
  input  logic [DATA_WIDTH-1:0] head_d,
  input  logic [DATA_WIDTH-1:0] value_d,
  output logic [DATA_WIDTH-1:0] data_q
);

  localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INS: begin
        // open a gap at idx: cells above take their left neighbor
        if (MY_IDX > ctl.idx) begin
          data_nxt = left_d;
        end else if (MY_IDX == ctl.idx) begin
          data_nxt = value_d;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctl.idx) begin
          data_nxt = right_d;
        end
      end
      CELL_ROT: begin
        // idx marks the last held cell, which wraps around to the head
        if (MY_IDX < ctl.idx) begin
          data_nxt = right_d;
        end else if (MY_IDX == ctl.idx) begin
          data_nxt = head_d;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

@@ src/positional_list_engine.sv @@
// Top level: command decode, element count and the chain of list cells.
// Edit commands (insert, delete, unused kind) return one result the cycle after the
// transaction, so a new transaction can follow every cycle. The receiver cannot stall results.
// A dump of N elements returns N results on consecutive cycles; busy stays high while the
// dump streams, one rotation step of the cell chain per cycle. An empty dump returns a single final result.
// Reset clears the count and the control state; list cells keep their contents until written.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count,
  output logic [ELEM_W-1:0]   out_element,
  output logic                out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  ple_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  ple_status_t         out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [ELEM_W-1:0]   out_element_r, out_element_nxt;
  logic                out_last_r, out_last_nxt;
  ple_cell_ctl_t       ctl;

  logic                  accept;
  logic [CMP_W-1:0]      held_x, pos_x, cap_x;
  logic [DATA_WIDTH-1:0] value_d;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  assign busy    = (state_r == ST_DUMP);
  assign accept  = start && !busy;
  assign held_x  = CMP_W'(held_r);
  assign pos_x   = CMP_W'(in_position);
  assign cap_x   = CMP_W'(CAPACITY);
  assign value_d = DATA_WIDTH'(in_value);

  always_comb begin
    state_nxt       = state_r;
    held_nxt        = held_r;
    rem_nxt         = rem_r;
    ctl.op          = CELL_HOLD;
    ctl.idx         = '0;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = STAT_OK;
    out_element_nxt = '0;
    out_last_nxt    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          case (in_kind)
            KIND_INS_FRONT, KIND_INS_BACK: begin
              if (held_x >= cap_x) begin
                out_status_nxt = STAT_FULL;
              end else begin
                ctl.op   = CELL_INS;
                ctl.idx  = (in_kind == KIND_INS_FRONT) ? '0 : CELL_IDX_W'(held_x);
                held_nxt = held_r + CNT_W'(1);
              end
            end
            KIND_INS_AT: begin
              if (pos_x == '0 || pos_x > held_x + CMP_W'(1)) begin
                out_status_nxt = STAT_BAD;
              end else if (held_x >= cap_x) begin
                out_status_nxt = STAT_FULL;
              end else begin
                ctl.op   = CELL_INS;
                ctl.idx  = CELL_IDX_W'(pos_x - CMP_W'(1));
                held_nxt = held_r + CNT_W'(1);
              end
            end
            KIND_DEL_FRONT, KIND_DEL_BACK: begin
              if (held_x == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                ctl.op   = CELL_DEL;
                ctl.idx  = (in_kind == KIND_DEL_FRONT) ? '0
                                                       : CELL_IDX_W'(held_x - CMP_W'(1));
                held_nxt = held_r - CNT_W'(1);
              end
            end
            KIND_DEL_AT: begin
              if (pos_x == '0) begin
                out_status_nxt = STAT_BAD;
              end else if (held_x == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else if (pos_x > held_x) begin
                out_status_nxt = STAT_BAD;
              end else begin
                ctl.op   = CELL_DEL;
                ctl.idx  = CELL_IDX_W'(pos_x - CMP_W'(1));
                held_nxt = held_r - CNT_W'(1);
              end
            end
            KIND_DUMP: begin
              if (held_x != '0) begin
                // emit the head now and rotate the held cells by one
                out_element_nxt = ELEM_W'(cell_q[0]);
                out_last_nxt    = (held_x == CMP_W'(1));
                ctl.op          = CELL_ROT;
                ctl.idx         = CELL_IDX_W'(held_x - CMP_W'(1));
                if (held_x != CMP_W'(1)) begin
                  state_nxt = ST_DUMP;
                  rem_nxt   = held_r - CNT_W'(1);
                end
              end
            end
            default: out_status_nxt = STAT_OK;
          endcase
        end
      end
      ST_DUMP: begin
        out_valid_nxt   = 1'b1;
        out_element_nxt = ELEM_W'(cell_q[0]);
        out_last_nxt    = (rem_r == CNT_W'(1));
        ctl.op          = CELL_ROT;
        ctl.idx         = CELL_IDX_W'(held_x - CMP_W'(1));
        rem_nxt         = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_count_nxt = COUNT_W'(held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[i+1];
    end

    ple_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_d  (left_d),
      .right_d (right_d),
      .head_d  (cell_q[0]),
      .value_d (value_d),
      .data_q  (cell_q[i])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_count   = out_count_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  // an edit transaction answers with one final result in the next cycle
  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind != KIND_DUMP) |=> out_valid && out_last)
    else $error("edit transaction did not produce a final result");

  // a dump stream has no gaps
  a_dump_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("dump stream broke before its last element");

  a_busy_emits: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("busy cycle did not emit a dump element");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_x <= cap_x)
    else $error("element count exceeds capacity");

  a_error_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_last && (out_element == '0))
    else $error("error result not final or carries an element");

endmodule

@@ sim/tb_positional_list_engine.sv @@
// Self-checking testbench for the positional list engine: directed and random command streams.
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 400;
  localparam int RANDOM_ITEMS = 110;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef enum int {
    EP_FILL,
    EP_DRAIN,
    EP_MIXED
  } episode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [ELEM_W-1:0]   element;
    logic                last;
  } list_result_t;

  class list_scoreboard;
    logic [ELEM_W-1:0] cells [LIST_CAP];
    int held;
    int errors;
    list_result_t expected [$];

    function new();
      held = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void push(logic [STATUS_W-1:0] status, logic [ELEM_W-1:0] element, logic last);
      list_result_t r;
      r.status = status;
      r.count = held[COUNT_W-1:0];
      r.element = element;
      r.last = last;
      expected.push_back(r);
    endfunction

    // open a hole at list position pos (1-based) and fill it
    function void put_at(int pos, logic [VALUE_W-1:0] value);
      for (int i = held; i >= pos; i--) cells[i] = cells[i-1];
      cells[pos-1] = value[ELEM_W-1:0];
      held++;
    endfunction

    function void take_at(int pos);
      for (int i = pos - 1; i < held - 1; i++) cells[i] = cells[i+1];
      held--;
    endfunction

    function void note_command(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] position);
      logic [STATUS_W-1:0] status;
      int pos;
      status = STAT_OK;
      pos = position;
      case (kind)
        KIND_INS_FRONT, KIND_INS_BACK: begin
          if (held >= LIST_CAP) status = STAT_FULL;
          else put_at(kind == KIND_INS_FRONT ? 1 : held + 1, value);
        end
        KIND_INS_AT: begin
          // position is judged before fullness
          if (pos < 1 || pos > held + 1) status = STAT_BAD;
          else if (held >= LIST_CAP) status = STAT_FULL;
          else put_at(pos, value);
        end
        KIND_DEL_FRONT, KIND_DEL_BACK: begin
          if (held == 0) status = STAT_EMPTY;
          else take_at(kind == KIND_DEL_FRONT ? 1 : held);
        end
        KIND_DEL_AT: begin
          if (pos < 1) status = STAT_BAD;
          else if (held == 0) status = STAT_EMPTY;
          else if (pos > held) status = STAT_BAD;
          else take_at(pos);
        end
        KIND_DUMP: begin
          if (held == 0) begin
            push(STAT_OK, '0, 1'b1);
          end else begin
            for (int i = 0; i < held; i++) push(STAT_OK, cells[i], i == held - 1);
          end
          return;
        end
        default: ;
      endcase
      push(status, '0, 1'b1);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                               logic [ELEM_W-1:0] element, logic last);
      list_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result status=%0d count=%0d element=%0h last=%0b",
                 $time, status, count, element, last);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, status);
        errors++;
      end
      if (count !== want.count) begin
        $display("%0t: count mismatch: expected %0d, actual %0d", $time, want.count, count);
        errors++;
      end
      if (element !== want.element) begin
        $display("%0t: element mismatch: expected %0h, actual %0h", $time, want.element,
                 element);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [VALUE_W-1:0]  in_value = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  logic [ELEM_W-1:0]   out_element;
  logic                out_last;

  list_scoreboard sb = new();
  int issued = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  positional_list_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .in_position(in_position),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_count  (out_count),
    .out_element(out_element),
    .out_last   (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_count, out_element, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_positional_list_engine: errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // hold start until the block takes the transaction, then idle at random
  task automatic issue(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                       input logic [POS_W-1:0] position);
    @(negedge clk);
    start <= 1'b1;
    in_kind <= kind;
    in_value <= value;
    in_position <= position;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(kind, value, position);
    issued++;
    pause(gap_len());
  endtask

  task automatic wait_drained();
    pause(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    return VALUE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [POS_W-1:0] rand_position();
    if ($urandom_range(0, 99) < 70) return POS_W'($urandom_range(1, sb.held + 1));
    return POS_W'($urandom_range(0, 31));
  endfunction

  task automatic fill_episode();
    int pick;
    while (sb.held < LIST_CAP) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) issue(KIND_INS_FRONT, rand_value(), POS_W'($urandom_range(0, 31)));
      else if (pick == 1) issue(KIND_INS_BACK, rand_value(), POS_W'($urandom_range(0, 31)));
      else issue(KIND_INS_AT, rand_value(), POS_W'($urandom_range(1, sb.held + 1)));
    end
    // poke the full list from every side
    issue(KIND_INS_FRONT, rand_value(), POS_W'($urandom_range(0, 31)));
    issue(KIND_INS_BACK, rand_value(), POS_W'($urandom_range(0, 31)));
    issue(KIND_INS_AT, rand_value(), POS_W'($urandom_range(1, LIST_CAP + 1)));
    issue(KIND_INS_AT, rand_value(), POS_W'($urandom_range(LIST_CAP + 2, 31)));
    issue(KIND_DUMP, rand_value(), POS_W'($urandom_range(0, 31)));
  endtask

  task automatic drain_episode();
    int pick;
    while (sb.held > 0) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) issue(KIND_DEL_FRONT, rand_value(), POS_W'($urandom_range(0, 31)));
      else if (pick == 1) issue(KIND_DEL_BACK, rand_value(), POS_W'($urandom_range(0, 31)));
      else issue(KIND_DEL_AT, rand_value(), POS_W'($urandom_range(1, sb.held)));
    end
    issue(KIND_W'($urandom_range(KIND_DEL_FRONT, KIND_DEL_AT)), rand_value(),
          POS_W'($urandom_range(0, 31)));
  endtask

  task automatic mixed_episode();
    repeat (8) issue(KIND_W'($urandom_range(0, 7)), rand_value(), rand_position());
  endtask

  initial begin
    episode_t ep;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(KIND_DUMP, 8'h00, 5'd0);
    issue(KIND_DEL_FRONT, 8'h00, 5'd0);
    issue(KIND_DEL_BACK, 8'h00, 5'd0);
    issue(KIND_DEL_AT, 8'h00, 5'd0);
    issue(KIND_DEL_AT, 8'h00, 5'd31);
    issue(KIND_INS_AT, 8'h12, 5'd0);
    issue(KIND_INS_AT, 8'h34, 5'd2);
    issue(KIND_INS_AT, 8'hFF, 5'd1);
    issue(KIND_INS_FRONT, 8'h00, 5'd0);
    issue(KIND_INS_BACK, 8'hA5, 5'd0);
    issue(KIND_INS_AT, 8'h5A, 5'd2);
    issue(KIND_INS_AT, 8'h11, 5'd31);
    issue(KIND_UNUSED, 8'hFF, 5'd31);
    issue(KIND_DUMP, 8'h00, 5'd0);
    issue(KIND_DEL_AT, 8'h00, 5'd5);
    issue(KIND_DEL_AT, 8'h00, 5'd0);
    issue(KIND_DEL_AT, 8'h00, 5'd2);
    issue(KIND_DEL_BACK, 8'h00, 5'd0);
    issue(KIND_DEL_FRONT, 8'h00, 5'd0);
    issue(KIND_DEL_AT, 8'h00, 5'd1);
    issue(KIND_INS_BACK, 8'h3C, 5'd0);
    issue(KIND_DEL_BACK, 8'h00, 5'd0);
    issue(KIND_INS_FRONT, 8'h81, 5'd0);
    issue(KIND_DEL_FRONT, 8'h00, 5'd0);
    issue(KIND_DUMP, 8'h00, 5'd0);
    wait_drained();

    ep = EP_FILL;
    while (issued < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 2) == 0);
      case (ep)
        EP_FILL:  fill_episode();
        EP_DRAIN: drain_episode();
        default:  mixed_episode();
      endcase
      if ($urandom_range(0, 2) == 0) wait_drained();
      ep = episode_t'($urandom_range(0, 2));
    end

    no_gaps = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_positional_list_engine: clean");
    end else begin
      $display("tb_positional_list_engine: errors");
    end
    $finish;
  end

endmodule
